// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the bitmap store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Types, codes and helper functions shared by the bitmap store engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  typedef enum logic [3:0] {
    OP_TEST = 4'd0, OP_SET = 4'd1, OP_CLEAR = 4'd2, OP_SET_ALL = 4'd3,
    OP_CLEAR_ALL = 4'd4, OP_FLIP_ALL = 4'd5, OP_COUNT = 4'd6, OP_FIND = 4'd7,
    OP_OR_WORD = 4'd8, OP_ANDNOT_WORD = 4'd9, OP_COUNT_MASKED = 4'd10
  } op_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_MASK  = 2'd2;

  localparam logic [12:0] TOTAL_MAX = 13'h1FFF;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_READ, ST_EXEC, ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [12:0] bit_index;
    logic        bit_value;
    logic [6:0]  word_index;
    logic [31:0] mask_word;
    logic [5:0]  mask_valid_bits;
  } req_t;

  typedef struct packed {
    logic        bit_out;
    logic [12:0] count;
    logic        found;
    logic [11:0] position;
    logic [1:0]  error;
  } rsp_t;

  // SWAR population count of one word
  function automatic logic [5:0] pop32(input logic [31:0] x);
    logic [31:0] y;
    y = x - ((x >> 1) & 32'h55555555);
    y = (y & 32'h33333333) + ((y >> 2) & 32'h33333333);
    y = (y + (y >> 4)) & 32'h0f0f0f0f;
    y = y + (y >> 8);
    y = y + (y >> 16);
    return y[5:0];
  endfunction

  // lowest set bit position, x nonzero
  function automatic logic [4:0] low_one(input logic [31:0] x);
    logic [31:0] y;
    logic [4:0]  p;
    y = x;
    p = '0;
    if (y[15:0] == 16'h0) begin y = y >> 16; p[4] = 1'b1; end
    if (y[7:0] == 8'h0) begin y = y >> 8; p[3] = 1'b1; end
    if (y[3:0] == 4'h0) begin y = y >> 4; p[2] = 1'b1; end
    if (y[1:0] == 2'h0) begin y = y >> 2; p[1] = 1'b1; end
    if (y[0] == 1'b0) p[0] = 1'b1;
    return p;
  endfunction

endpackage

// ===== rtl/bse_req_if.sv =====
// ----------------------------------------------------------------------------
// bse_req_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface bse_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [12:0] bit_index;
  logic        bit_value;
  logic [6:0]  word_index;
  logic [31:0] mask_word;
  logic [5:0]  mask_valid_bits;
  modport source (output valid, op, bit_index, bit_value, word_index, mask_word,
                  mask_valid_bits, input ready);
  modport sink (input valid, op, bit_index, bit_value, word_index, mask_word,
                mask_valid_bits, output ready);
endinterface

interface bse_rsp_if;
  logic        valid;
  logic        ready;
  logic        bit_out;
  logic [12:0] count;
  logic        found;
  logic [11:0] position;
  logic [1:0]  error;
  modport source (output valid, bit_out, count, found, position, error, input ready);
  modport sink (input valid, bit_out, count, found, position, error, output ready);
endinterface

interface bse_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/bse_mem.sv =====
// ----------------------------------------------------------------------------
// bse_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bse_mem #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bitmap_store_engine_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_store_engine_core
// Bit vector store in one word memory with a read-modify-write sequencer.
//
// Channels: req (sink) carries one operation per beat; rsp (source) returns
// exactly one result beat per request; cfg (sink) writes vector_length and
// may be written only while the block is idle.
// Timing: single-bit and mask-word ops pass through the read state and the
// execute/write state before the result beat. Whole-vector ops read one
// word per cycle over nw = ceil(length/32) words; find stops at the first
// word holding a match. Errors, unknown ops, zero-length walks and a find
// starting at the length skip the execute state and go from read straight
// to the result. Throughput: one item at a time; the next request is taken
// in the cycle after the result beat.
// Reset: after rst a clearing pass writes zero to all STORE_WORDS words, one
// per cycle; requests wait during it, configuration writes are taken.
// Stall: a result held by a low rsp.ready stays on the port unchanged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bitmap_store_engine_core #(
  parameter int STORE_WORDS = 128
) (
  input logic clk,
  input logic rst,
  bse_req_if.sink   req,
  bse_rsp_if.source rsp,
  bse_cfg_if.sink   cfg
);
  import bse_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CAP = STORE_WORDS * 32;
  localparam int CW = $clog2(STORE_WORDS + 1);

  state_t state, state_next;
  logic [12:0] vector_length;
  logic [12:0] masked_total;
  req_t        cur;
  rsp_t        res;
  logic [CW-1:0] widx;       // current word in walks / clearing pass
  logic [12:0] len;
  logic [CW-1:0] nw;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  bse_mem #(.DEPTH(STORE_WORDS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // effective length and word count
  always_comb begin
    if (32'(vector_length) < CAP) len = vector_length;
    else len = 13'(CAP);
    nw = CW'((32'(len) + 31) >> 5);
  end

  // op classes and range checks
  logic is_bit, is_walk, is_find, is_mask, bad;
  logic [5:0] vb;
  logic [31:0] mmask;
  always_comb begin
    is_bit  = cur.op <= 4'(OP_CLEAR);
    is_walk = cur.op >= 4'(OP_SET_ALL) && cur.op <= 4'(OP_COUNT);
    is_find = cur.op == 4'(OP_FIND);
    is_mask = cur.op >= 4'(OP_OR_WORD) && cur.op <= 4'(OP_COUNT_MASKED);
    vb = (cur.mask_valid_bits > 6'd32) ? 6'd32 : cur.mask_valid_bits;
    mmask = (vb == 6'd32) ? cur.mask_word : (cur.mask_word & ((32'd1 << vb) - 32'd1));
    bad = 1'b0;
    if (is_bit) bad = cur.bit_index >= len;
    if (is_find) bad = cur.bit_index > len;
    if (is_mask) bad = (32'(cur.word_index) >= STORE_WORDS) ||
                       ({cur.word_index, 5'd0} + 13'(vb) > len);
  end

  // mask of word widx below the length
  logic [31:0] wmask;
  logic [12:0] wbase;
  always_comb begin
    wbase = 13'(32'(widx) << 5);
    if (wbase >= len) wmask = '0;
    else if (len - wbase >= 13'd32) wmask = '1;
    else wmask = (32'd1 << (len - wbase)) - 32'd1;
  end

  // find candidate in the word just read
  logic [31:0] fw;
  always_comb begin
    fw = (cur.bit_value ? rdata : ~rdata) & wmask;
    if (widx == CW'(cur.bit_index >> 5)) fw = fw & (32'hFFFFFFFF << cur.bit_index[4:0]);
  end

  logic walk_done;
  assign walk_done = (widx + CW'(1)) >= nw;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (32'(widx) == STORE_WORDS - 1) state_next = ST_IDLE;
      ST_IDLE: if (req.valid) state_next = ST_READ;
      ST_READ: begin
        if (bad || (!is_bit && !is_walk && !is_find && !is_mask)) state_next = ST_OUT;
        else if (is_walk && nw == '0) state_next = ST_OUT;
        else if (is_find && cur.bit_index == len) state_next = ST_OUT;
        else state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_bit || is_mask) state_next = ST_OUT;
        else if (is_find && fw != '0) state_next = ST_OUT;
        else if (walk_done) state_next = ST_OUT;
      end
      ST_OUT:  if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control and outputs
  logic [31:0] mod;
  always_comb begin
    we = 1'b0;
    waddr = widx[AW-1:0];
    wdata = '0;
    raddr = widx[AW-1:0];
    mod = rdata;
    unique case (state)
      ST_CLR: we = 1'b1;
      ST_READ: begin
        if (is_bit) raddr = cur.bit_index[AW+4:5];
        else if (is_mask) raddr = cur.word_index[AW-1:0];
        else if (is_find) raddr = AW'(cur.bit_index >> 5);
        else raddr = '0;
      end
      ST_EXEC: begin
        raddr = AW'(widx + CW'(1));
        if (is_bit) begin
          waddr = cur.bit_index[AW+4:5];
          if (cur.op == 4'(OP_SET)) begin
            mod = rdata | (32'd1 << cur.bit_index[4:0]); we = 1'b1;
          end else if (cur.op == 4'(OP_CLEAR)) begin
            mod = rdata & ~(32'd1 << cur.bit_index[4:0]); we = 1'b1;
          end
        end else if (is_mask) begin
          waddr = cur.word_index[AW-1:0];
          if (cur.op == 4'(OP_OR_WORD)) begin mod = rdata | mmask; we = 1'b1; end
          else if (cur.op == 4'(OP_ANDNOT_WORD)) begin mod = rdata & ~mmask; we = 1'b1; end
        end else if (is_walk) begin
          if (cur.op == 4'(OP_SET_ALL)) begin mod = rdata | wmask; we = 1'b1; end
          else if (cur.op == 4'(OP_CLEAR_ALL)) begin mod = rdata & ~wmask; we = 1'b1; end
          else if (cur.op == 4'(OP_FLIP_ALL)) begin mod = rdata ^ wmask; we = 1'b1; end
        end
        wdata = mod;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == ST_OUT);
  assign rsp.bit_out = res.bit_out;
  assign rsp.count = res.count;
  assign rsp.found = res.found;
  assign rsp.position = res.position;
  assign rsp.error = res.error;

  // datapath registers
  logic [13:0] tsum;
  always_comb begin
    tsum = ((cur.word_index == '0) ? 14'd0 : {1'b0, masked_total}) +
           14'(pop32(rdata & mmask));
  end

  function automatic logic [7:0] req_idx_word(input logic [12:0] b);
    return b[12:5];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      widx <= '0;
      vector_length <= 13'd4096;
      masked_total <= '0;
      res <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) vector_length <= cfg.data;
      unique case (state)
        ST_CLR: widx <= widx + CW'(1);
        ST_IDLE: if (req.valid) begin
          cur <= '{op: req.op, bit_index: req.bit_index, bit_value: req.bit_value,
                   word_index: req.word_index, mask_word: req.mask_word,
                   mask_valid_bits: req.mask_valid_bits};
          res <= '0;
        end
        ST_READ: begin
          widx <= is_find ? CW'(req_idx_word(cur.bit_index)) : '0;
          if (bad) res.error <= is_mask ? ERR_MASK : ERR_INDEX;
        end
        ST_EXEC: begin
          widx <= widx + CW'(1);
          if (is_bit && cur.op == 4'(OP_TEST)) res.bit_out <= rdata[cur.bit_index[4:0]];
          if (cur.op == 4'(OP_COUNT)) res.count <= res.count + 13'(pop32(rdata & wmask));
          if (cur.op == 4'(OP_COUNT_MASKED)) begin
            masked_total <= (tsum > 14'(TOTAL_MAX)) ? TOTAL_MAX : tsum[12:0];
            res.count <= (tsum > 14'(TOTAL_MAX)) ? TOTAL_MAX : tsum[12:0];
          end
          if (is_find && fw != '0) begin
            res.found <= 1'b1;
            res.position <= 12'({widx, low_one(fw)});
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_one_busy, clk, rst, rsp.valid, !req.ready, "result and accept overlap")
  `ASSERT_IMPLIES(a_err_clean, clk, rst, rsp.valid && rsp.error != ERR_NONE, rsp.count == '0 && !rsp.found, "error result carries data")
  `ASSERT_NEXT(a_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
endmodule
